FILE: src/rsa_pkg.sv
package rsa_pkg;

    // table geometry
    localparam int SLOTS       = 32;
    localparam int SLOT_W      = 5;
    localparam int CNT_W       = 6;
    localparam int HANDLE_BITS = 32;
    localparam int REF_W       = 16;
    localparam int STATUS_W    = 3;

    // stream widths: payload packed from bit 0 upwards, padded to bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 1'b1;
    localparam logic [CNT_W-1:0]     MAX_SLOTS_RST = 6'd16;

    // request kinds
    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REUSE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEWTOP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STILL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRIMMED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd7;

    localparam logic [REF_W-1:0] COUNT_MAX = '1;

    // write bundle broadcast to every slot cell
    typedef struct packed {
        logic                   load_handle;
        logic                   occupied;
        logic [REF_W-1:0]       count;
        logic [HANDLE_BITS-1:0] handle;
    } t_cell_wr;

endpackage

FILE: src/rsa_ram.sv
module rsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rsa_cell.sv
module rsa_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rst_occupied,
    input  logic                           i_cfg_load,
    input  logic [rsa_pkg::HANDLE_BITS-1:0] i_cfg_handle,
    input  logic [rsa_pkg::HANDLE_BITS-1:0] i_req_handle,
    input  logic                           i_hit_below,
    output logic                           o_hit_above,
    output logic                           o_first,
    input  logic                           i_we,
    input  rsa_pkg::t_cell_wr              i_wr,
    output logic [rsa_pkg::REF_W-1:0]      o_count,
    output logic                           o_occupied
);

    import rsa_pkg::*;

    logic                   r_occupied;
    logic [REF_W-1:0]       r_count;
    logic [HANDLE_BITS-1:0] r_handle;
    logic                   match;

    // slot state; reset value of the reserved slot comes in on i_rst_occupied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied <= i_rst_occupied;
            r_count    <= REF_W'(i_rst_occupied);
            r_handle   <= '0;
        end else begin
            if (i_cfg_load) begin
                r_handle <= i_cfg_handle;
            end
            if (i_we) begin
                r_occupied <= i_wr.occupied;
                r_count    <= i_wr.count;
                if (i_wr.load_handle) begin
                    r_handle <= i_wr.handle;
                end
            end
        end
    end

    // local compare, then pass "hit seen below" on to the next cell up
    assign match       = r_occupied && (r_handle == i_req_handle);
    assign o_hit_above = i_hit_below | match;
    assign o_first     = match & ~i_hit_below;
    assign o_count     = r_count;
    assign o_occupied  = r_occupied;

endmodule

FILE: src/refcounted_slot_allocator.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: handle, slot_in
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: slot, status, ref_count
// cfg       in   i_cfg_we (no wait)           i_cfg_idx, i_cfg_wdata
//
// Each item passes through a compare cycle across the row of slot cells
// (handle match and lowest-hit chain), then an update cycle that writes the
// selected cell, the free FIFO and the high-water mark and loads the result.
// The next transfer is taken during the update cycle when the output register
// is free or being drained; a stalled m_axis holds the block in its update cycle.
// Reset is synchronous; no clearing pass, slot 0 holds the reserved handle.
module refcounted_slot_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rsa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // handle[31:0], slot_in[36:32]
    input  logic                             s_axis_tuser,  // kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // slot[4:0], status[7:5],
                                                            // ref_count[23:8]
);

    import rsa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;

    logic [1:0]             r_state, n_state;
    logic                   r_kind;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOTS-1:0]       r_sel;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_hit;
    logic [CNT_W-1:0]       r_max_slots;
    logic [CNT_W-1:0]       r_hw, n_hw;
    logic [SLOT_W-1:0]      r_head, r_tail;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   in_acc;
    logic                   upd_go;
    logic [SLOTS:0]         hit_chain;
    logic [SLOTS-1:0]       first_vec;
    logic [SLOTS-1:0]       cell_we;
    logic [REF_W-1:0]       cell_count [SLOTS];
    logic [SLOTS-1:0]       cell_occ;
    t_cell_wr               cell_wr;
    logic [SLOT_W-1:0]      first_idx;
    logic [REF_W-1:0]       sel_count;
    logic                   sel_occ;
    logic [SLOT_W-1:0]      fifo_rdata;
    logic                   push, pop;
    logic [CNT_W-1:0]       limit;
    logic [SLOT_W-1:0]      grant_idx;
    logic [SLOT_W-1:0]      o_slot;
    logic [STATUS_W-1:0]    o_status;
    logic [REF_W-1:0]       o_count;
    logic [REF_W-1:0]       dec_count;

    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign upd_go        = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE) || upd_go;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) n_state = in_acc ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= s_axis_tuser;
            r_handle <= s_axis_tdata[HANDLE_BITS-1:0];
            r_slot   <= s_axis_tdata[HANDLE_BITS +: SLOT_W];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slots <= MAX_SLOTS_RST;
        end else if (i_cfg_we && i_cfg_idx == CFG_MAX_SLOTS) begin
            r_max_slots <= i_cfg_wdata[CNT_W-1:0];
        end
    end

    // row of slot cells
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        rsa_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_rst_occupied (g == 0),
            .i_cfg_load     ((g == 0) && i_cfg_we && (i_cfg_idx == CFG_RESERVED)),
            .i_cfg_handle   (i_cfg_wdata[HANDLE_BITS-1:0]),
            .i_req_handle   (r_handle),
            .i_hit_below    (hit_chain[g]),
            .o_hit_above    (hit_chain[g+1]),
            .o_first        (first_vec[g]),
            .i_we           (cell_we[g]),
            .i_wr           (cell_wr),
            .o_count        (cell_count[g]),
            .o_occupied     (cell_occ[g])
        );
    end

    // encode the lowest hit
    always_comb begin
        first_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (first_vec[i]) first_idx = first_idx | SLOT_W'(i);
        end
    end

    // selection for the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH) begin
            if (r_kind == KIND_RELEASE) begin
                r_sel <= SLOTS'(1) << r_slot;
                r_idx <= r_slot;
                r_hit <= 1'b0;
            end else begin
                r_sel <= first_vec;
                r_idx <= first_idx;
                r_hit <= hit_chain[SLOTS];
            end
        end
    end

    // read the selected cell through the one-hot select
    always_comb begin
        sel_count = '0;
        sel_occ   = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_sel[i]) begin
                sel_count = sel_count | cell_count[i];
                sel_occ   = sel_occ | cell_occ[i];
            end
        end
    end

    // free slot FIFO; head is read during the compare cycle
    rsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (upd_go && push),
        .i_waddr (r_tail),
        .i_wdata (r_slot),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    assign limit     = (r_max_slots < CNT_W'(SLOTS)) ? r_max_slots : CNT_W'(SLOTS);
    assign dec_count = (sel_count != '0) ? sel_count - REF_W'(1) : sel_count;

    // update decision
    always_comb begin
        cell_we             = '0;
        cell_wr.load_handle = 1'b0;
        cell_wr.occupied    = 1'b1;
        cell_wr.count       = REF_W'(1);
        cell_wr.handle      = r_handle;
        push                = 1'b0;
        pop                 = 1'b0;
        n_hw                = r_hw;
        grant_idx           = '0;
        o_slot              = '0;
        o_status            = ST_IGNORED;
        o_count             = '0;
        if (r_kind == KIND_ACQUIRE) begin
            if (r_hit) begin
                cell_we       = r_sel;
                cell_wr.count = (sel_count == COUNT_MAX) ? sel_count : sel_count + REF_W'(1);
                o_slot        = r_idx;
                o_status      = ST_HIT;
                o_count       = cell_wr.count;
            end else if (r_fill != '0) begin
                pop                 = 1'b1;
                grant_idx           = fifo_rdata;
                cell_we             = SLOTS'(1) << grant_idx;
                cell_wr.load_handle = 1'b1;
                o_slot              = grant_idx;
                o_status            = ST_REUSE;
                o_count             = REF_W'(1);
            end else if ({1'b0, r_hw} + 7'd1 <= {1'b0, limit}) begin
                grant_idx           = r_hw[SLOT_W-1:0];
                cell_we             = SLOTS'(1) << grant_idx;
                cell_wr.load_handle = 1'b1;
                n_hw                = r_hw + CNT_W'(1);
                o_slot              = grant_idx;
                o_status            = ST_NEWTOP;
                o_count             = REF_W'(1);
            end else begin
                o_status = ST_FULL;
            end
        end else begin
            o_slot = r_slot;
            if (r_slot == '0) begin
                o_count = sel_count;
            end else if (!sel_occ) begin
                o_status = ST_IGNORED;
            end else if (dec_count != '0) begin
                cell_we       = r_sel;
                cell_wr.count = dec_count;
                o_status      = ST_STILL;
                o_count       = dec_count;
            end else begin
                // count reached zero: the slot is freed
                cell_we          = r_sel;
                cell_wr.count    = '0;
                cell_wr.occupied = 1'b0;
                if ({1'b0, r_slot} + CNT_W'(1) >= r_hw) begin
                    if (r_hw > CNT_W'(1)) n_hw = r_hw - CNT_W'(1);
                    o_status = ST_TRIMMED;
                end else begin
                    push     = (r_fill < CNT_W'(SLOTS));
                    o_status = ST_QUEUED;
                end
            end
        end
        if (!upd_go) cell_we = '0;
    end

    always_comb begin
        n_fill = r_fill;
        if (push) n_fill = r_fill + CNT_W'(1);
        if (pop)  n_fill = r_fill - CNT_W'(1);
    end

    // high-water mark and FIFO pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw   <= CNT_W'(1);
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (upd_go) begin
            r_hw   <= n_hw;
            r_fill <= n_fill;
            if (pop)  r_head <= r_head + SLOT_W'(1);
            if (push) r_tail <= r_tail + SLOT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_data <= {o_count, o_status, o_slot};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // at most one cell selected for the update
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(r_sel))
        else $error("more than one slot cell selected");

    // the reserved slot never enters the free FIFO
    a_pop_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && pop) |-> (fifo_rdata != '0))
        else $error("reserved slot popped from free FIFO");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(SLOTS))
        else $error("free FIFO fill out of range");

    a_hw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw != '0 && cell_occ[0])
        else $error("reserved slot lost or high-water mark cleared");

    // a result appears only out of the update cycle
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("result loaded outside the update cycle");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import rsa_pkg::*;

    // one request and one grant as they travel on the streams
    typedef struct packed {
        logic                   kind;
        logic [HANDLE_BITS-1:0] handle;
        logic [SLOT_W-1:0]      slot_in;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    ref_count;
    } grant_t;

    typedef struct packed {
        request_t req;
        logic     pinned;
        grant_t   want;
    } script_row_t;

    localparam grant_t NO_WANT = '0;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_DEPTH = 40;

    // directed script, run with max_slots 4 and reserved handle all ones
    localparam script_row_t DIRECTED [23] = '{
        // slot 0 cannot be released; reserved handle hits slot 0
        '{'{KIND_RELEASE, 32'hFFFF_FFFF, 5'd0},  1'b1, '{5'd0,  ST_IGNORED, 16'd1}},
        '{'{KIND_ACQUIRE, 32'hFFFF_FFFF, 5'd31}, 1'b1, '{5'd0,  ST_HIT,     16'd2}},
        // grow to the limit, then full
        '{'{KIND_ACQUIRE, 32'h0000_0000, 5'd31}, 1'b1, '{5'd1,  ST_NEWTOP,  16'd1}},
        '{'{KIND_ACQUIRE, 32'h1234_5678, 5'd0},  1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h0000_0000, 5'd21}, 1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'hA5A5_A5A5, 5'd10}, 1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h5A5A_5A5A, 5'd31}, 1'b1, '{5'd0,  ST_FULL,    16'd0}},
        // free slot released
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd31}, 1'b1, '{5'd31, ST_IGNORED, 16'd0}},
        // still used, then queued free twice, then reused in order
        '{'{KIND_RELEASE, 32'hFFFF_FFFF, 5'd1},  1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd1},  1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'hFFFF_FFFF, 5'd2},  1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h5A5A_5A5A, 5'd0},  1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h0000_0001, 5'd31}, 1'b0, NO_WANT},
        // top slot trimmed, second release of it ignored
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd3},  1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'hFFFF_FFFF, 5'd3},  1'b1, '{5'd3,  ST_IGNORED, 16'd0}},
        '{'{KIND_ACQUIRE, 32'hDEAD_BEEF, 5'd0},  1'b0, NO_WANT},
        // queue one, trim down to it
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd1},  1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'hFFFF_FFFF, 5'd3},  1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd2},  1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h5A5A_5A5A, 5'd31}, 1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'h0000_0007, 5'd0},  1'b0, NO_WANT},
        '{'{KIND_ACQUIRE, 32'hFFFF_FFFF, 5'd31}, 1'b0, NO_WANT},
        '{'{KIND_RELEASE, 32'h0000_0000, 5'd0},  1'b0, NO_WANT}
    };

    // random phases: slot limit and idling per side
    localparam logic [CNT_W-1:0] PHASE_LIMIT [8] = '{6'd32, 6'd1, 6'd63, 6'd0,
                                                     6'd5, 6'd3, 6'd32, 6'd16};
    localparam int PHASE_TX [8] = '{0, 55, 0, 7, 55, 0, 7, 0};
    localparam int PHASE_RX [8] = '{0, 0, 55, 7, 0, 55, 7, 0};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // grant typed into the script travels alongside the request
    logic   pin_en = 1'b0;
    grant_t pin_want = '0;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    event hold_output;

    // predicted allocator state
    logic [HANDLE_BITS-1:0] slot_handle [SLOTS];
    logic [REF_W-1:0]       slot_refs [SLOTS];
    logic                   slot_used [SLOTS];
    int unsigned            top_mark;
    logic [SLOT_W-1:0]      recycled [$];
    logic [CNT_W-1:0]       cfg_max_slots;

    grant_t expected_grants [$];
    int     errors = 0;

    logic [HANDLE_BITS-1:0] handle_pool [POOL_DEPTH];
    int                     pool_n;

    refcounted_slot_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // handle[31:0], slot_in[36:32]
        .s_axis_tuser  (s_axis_tuser),   // kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // slot[4:0], status[7:5], ref_count[23:8]
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic clear_allocation();
        int k;
        for (k = 0; k < SLOTS; k++) begin
            slot_handle[k] = '0;
            slot_refs[k] = '0;
            slot_used[k] = 1'b0;
        end
        cfg_max_slots = MAX_SLOTS_RST;
        slot_handle[0] = '0;
        slot_refs[0] = REF_W'(1);
        slot_used[0] = 1'b1;
        top_mark = 1;
        recycled.delete();
    endtask

    // applies one request to the predicted table and returns its grant
    function automatic grant_t predict_allocation(request_t r);
        int          idx;
        int unsigned limit;
        int unsigned s;
        s = 32'(r.slot_in);
        if (r.kind == KIND_ACQUIRE) begin
            // lowest occupied slot with the same handle wins
            for (idx = 0; idx < SLOTS; idx++) begin
                if (slot_used[idx] && slot_handle[idx] == r.handle) begin
                    if (slot_refs[idx] != COUNT_MAX)
                        slot_refs[idx]++;
                    return '{SLOT_W'(idx), ST_HIT, slot_refs[idx]};
                end
            end
            if (recycled.size() != 0) begin
                idx = int'(recycled.pop_front());
                slot_handle[idx] = r.handle;
                slot_refs[idx] = REF_W'(1);
                slot_used[idx] = 1'b1;
                return '{SLOT_W'(idx), ST_REUSE, REF_W'(1)};
            end
            limit = (int'(cfg_max_slots) < SLOTS) ? int'(cfg_max_slots) : SLOTS;
            if (top_mark + 1 <= limit) begin
                idx = top_mark;
                slot_handle[idx] = r.handle;
                slot_refs[idx] = REF_W'(1);
                slot_used[idx] = 1'b1;
                top_mark++;
                return '{SLOT_W'(idx), ST_NEWTOP, REF_W'(1)};
            end
            return '{SLOT_W'(0), ST_FULL, REF_W'(0)};
        end
        if (s == 0)
            return '{SLOT_W'(0), ST_IGNORED, slot_refs[0]};
        if (!slot_used[s])
            return '{SLOT_W'(s), ST_IGNORED, REF_W'(0)};
        if (slot_refs[s] != 0)
            slot_refs[s]--;
        if (slot_refs[s] != 0)
            return '{SLOT_W'(s), ST_STILL, slot_refs[s]};
        slot_used[s] = 1'b0;
        if (s + 1 >= top_mark) begin
            if (top_mark > 1)
                top_mark--;
            return '{SLOT_W'(s), ST_TRIMMED, REF_W'(0)};
        end
        if (recycled.size() < SLOTS)
            recycled = {recycled, SLOT_W'(s)};
        return '{SLOT_W'(s), ST_QUEUED, REF_W'(0)};
    endfunction

    // mostly pool handles and live slots, with some noise
    function automatic request_t random_request();
        request_t    r;
        int unsigned start;
        int unsigned k;
        int unsigned c;
        r.kind = ($urandom_range(99) < 45) ? KIND_RELEASE : KIND_ACQUIRE;
        r.handle = ($urandom_range(99) < 85) ? handle_pool[$urandom_range(pool_n - 1)]
                                             : $urandom();
        r.slot_in = SLOT_W'($urandom_range(31));
        if (r.kind == KIND_RELEASE && $urandom_range(99) < 75) begin
            start = $urandom_range(30);
            for (k = 0; k < SLOTS - 1; k++) begin
                c = 1 + (start + k) % (SLOTS - 1);
                if (slot_used[c]) begin
                    r.slot_in = SLOT_W'(c);
                    break;
                end
            end
        end
        return r;
    endfunction

    // offers one request; tvalid stays up after the transfer unless a gap follows
    task automatic send_request(request_t r, logic pin, grant_t want);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, r.slot_in, r.handle};
        s_axis_tuser <= r.kind;
        pin_en <= pin;
        pin_want <= want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_config(logic [CNT_W-1:0] slots_limit,
                                  logic [HANDLE_BITS-1:0] reserved);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_MAX_SLOTS;
        i_cfg_wdata <= CFG_DATA_W'(slots_limit);
        @(posedge i_clk);
        i_cfg_idx <= CFG_RESERVED;
        i_cfg_wdata <= reserved;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // output side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        forever begin
            @(hold_output);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // register writes, accepted requests and returned grants
    always @(posedge i_clk) begin
        request_t taken;
        grant_t   got;
        grant_t   want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_SLOTS) begin
                    cfg_max_slots = i_cfg_wdata[CNT_W-1:0];
                end else begin
                    slot_handle[0] = i_cfg_wdata;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                taken.kind = s_axis_tuser;
                taken.handle = s_axis_tdata[31:0];
                taken.slot_in = s_axis_tdata[36:32];
                want = predict_allocation(taken);
                expected_grants = {expected_grants, (pin_en ? pin_want : want)};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot = m_axis_tdata[4:0];
                got.status = m_axis_tdata[7:5];
                got.ref_count = m_axis_tdata[23:8];
                if (expected_grants.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected transfer: slot %0d status %0d count %0d",
                                 $realtime, got.slot, got.status, got.ref_count);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.slot !== want.slot || got.status !== want.status ||
                        got.ref_count !== want.ref_count) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected slot %0d status %0d count %0d, %s %0d %0d %0d",
                                     $realtime, want.slot, want.status, want.ref_count,
                                     "got", got.slot, got.status, got.ref_count);
                    end
                end
            end
        end
    end

    initial begin
        logic [HANDLE_BITS-1:0] reserved;
        int                     p;
        int                     n;

        clear_allocation();
        pool_n = 2;
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed script on a four-slot table
        program_config(6'd4, 32'hFFFF_FFFF);
        for (n = 0; n < 23; n++)
            send_request(DIRECTED[n].req, DIRECTED[n].pinned, DIRECTED[n].want);
        wait_drained();

        // random phases; reserved handle often collides with a live handle
        for (p = 0; p < 8; p++) begin
            if (p == 0)
                reserved = '0;
            else if (p == 7)
                reserved = '1;
            else
                reserved = handle_pool[$urandom_range(pool_n - 1)];
            program_config(PHASE_LIMIT[p], reserved);
            tx_idle_pct = PHASE_TX[p];
            rx_stall_pct = PHASE_RX[p];
            pool_n = $urandom_range(4, POOL_DEPTH);
            for (n = 0; n < POOL_DEPTH; n++)
                handle_pool[n] = $urandom();
            handle_pool[0] = '0;
            handle_pool[1] = '1;
            // output held off while requests keep coming
            if (PHASE_RX[p] != 0)
                -> hold_output;
            repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, NO_WANT);
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (errors == 0 && expected_grants.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
